### src/mtm_pkg.sv
// ----------------------------------------------------------------------------
// mtm_pkg
// shared constants and types for the trimmed median unit
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int MAX_SAMPLES_DEF  = 64;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int COUNT_W  = 12;  // sample_count / median_count port width
  localparam int KEPT_W   = 7;   // kept_count port width
  localparam int FACTOR_W = 8;   // mad factor register width

  localparam int          MIN_MAD          = 2;
  localparam int          MIN_TRIM_COUNT   = 3;
  localparam logic [7:0]  MAD_FACTOR_RESET = 8'd3;

  // operation applied to every cell of a chain in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

endpackage

### src/mad_trimmed_median_unit.sv
// ----------------------------------------------------------------------------
// mad_trimmed_median_unit
// median of a window of adc counts with outlier rejection by mad
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one sample_count per beat, last_sample
//   closes the window. samples are insertion sorted into a chain of cells as
//   they arrive, one beat per cycle while loading.
//   beats beyond MAX_SAMPLES are dropped; a dropped last beat still closes.
//   after the last beat the unit stops taking beats and makes up to five
//   rotation passes over the cell chains (median, deviations, mad, keep
//   count, kept median), plus a step to form the limit and a step to load
//   the output register.
//   out_valid rises after the median pass alone when trimming is off or
//   fewer than three counts are held, after four passes when under half
//   survive and after all five otherwise; each pass runs over all
//   MAX_SAMPLES cells, whatever the window size.
//   output channel (out_valid/out_ready): one beat per window, held in an
//   output register; loading the next window goes on while it waits, but a
//   new result cannot be written until the old one is taken.
//   config channel (cfg_valid/cfg_ready, cfg_data): writes mad_factor, always
//   ready; the user must write it only while idle, the unit does not enforce it.
//   reset: empties both chains, window fill 0, mad_factor 3, no result.
// ----------------------------------------------------------------------------
module mad_trimmed_median_unit import mtm_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COUNT_W-1:0]  sample_count,
  input  logic                last_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  median_count,
  output logic [KEPT_W-1:0]   kept_count,
  output logic                used_full_window,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FACTOR_W-1:0] cfg_data
);

  localparam int N  = MAX_SAMPLES;
  localparam int W  = SAMPLE_BITS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int LW = W + FACTOR_W;

  typedef enum logic [2:0] {
    S_LOAD, S_MED, S_DEV, S_MAD, S_LIM, S_CNT, S_FIN, S_EMIT
  } state_t;

  state_t              state;
  logic [IW-1:0]       idx;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       n;
  logic [CW-1:0]       sel_base;
  logic [CW-1:0]       sel_k;
  logic [W-1:0]        lo, hi;
  logic [W-1:0]        m;
  logic [W-1:0]        mad;
  logic [LW-1:0]       limit;
  logic [CW-1:0]       kept;
  logic [CW-1:0]       first;
  logic [W-1:0]        res_med;
  logic [CW-1:0]       res_k;
  logic                res_full;
  logic [FACTOR_W-1:0] mad_factor;

  cell_op_t     s_op, d_op;
  logic [W-1:0] s_head, d_head, d_ins, sample_w;
  logic         s_head_valid, d_head_valid;

  // chain under readout in the current pass
  logic [W-1:0] rd_head;
  logic [CW-1:0] idx_ext, mid, fill_new, kept_final, first_final;
  logic          cap_lo, cap_hi, pass_end, hit, fill_room;
  logic [W-1:0]  cur_lo, cur_hi, mid_val, dev;

  assign sample_w  = W'(sample_count);
  assign fill_room = fill < CW'(N);
  assign fill_new  = fill_room ? fill + CW'(1) : fill;

  assign idx_ext  = CW'(idx);
  assign pass_end = idx == IW'(N - 1);
  assign rd_head  = (state == S_MAD) ? d_head : s_head;

  // pick the middle element(s) of a sorted run as it streams past the head
  assign mid     = sel_base + (sel_k >> 1);
  assign cap_lo  = ({1'b0, idx_ext} + (CW+1)'(1)) == {1'b0, mid};
  assign cap_hi  = idx_ext == mid;
  assign cur_lo  = cap_lo ? rd_head : lo;
  assign cur_hi  = cap_hi ? rd_head : hi;
  assign mid_val = sel_k[0] ? cur_hi : W'(({1'b0, cur_lo} + {1'b0, cur_hi}) >> 1);

  assign dev   = (s_head > m) ? s_head - m : m - s_head;
  assign d_ins = dev;
  assign hit   = s_head_valid && (LW'(dev) <= limit);

  assign kept_final  = hit ? kept + CW'(1) : kept;
  assign first_final = (hit && kept == '0) ? idx_ext : first;

  always_comb begin
    s_op = CELL_HOLD;
    d_op = CELL_HOLD;
    case (state)
      S_LOAD: if (in_valid && fill_room) s_op = CELL_INSERT;
      S_MED:  begin s_op = CELL_SHIFT; d_op = CELL_CLEAR; end
      S_DEV:  begin
        s_op = CELL_SHIFT;
        if (s_head_valid) d_op = CELL_INSERT;
      end
      S_MAD:  d_op = CELL_SHIFT;
      S_CNT:  s_op = CELL_SHIFT;
      S_FIN:  s_op = CELL_SHIFT;
      S_EMIT: s_op = CELL_CLEAR;
      default: begin s_op = CELL_HOLD; d_op = CELL_HOLD; end
    endcase
  end

  assign in_ready  = state == S_LOAD;
  assign cfg_ready = 1'b1;

  // sorted window samples
  mtm_sort_chain #(.N(N), .W(W)) u_samples (
    .clk       (clk),
    .rst       (rst),
    .op        (s_op),
    .ins_data  (sample_w),
    .head_data (s_head),
    .head_valid(s_head_valid)
  );

  // sorted absolute deviations
  mtm_sort_chain #(.N(N), .W(W)) u_devs (
    .clk       (clk),
    .rst       (rst),
    .op        (d_op),
    .ins_data  (d_ins),
    .head_data (d_head),
    .head_valid(d_head_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      fill       <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
      mad_factor <= MAD_FACTOR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) mad_factor <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cap_lo) lo <= rd_head;
      if (cap_hi) hi <= rd_head;
      if (state != S_LOAD && state != S_LIM && state != S_EMIT) idx <= idx + IW'(1);

      case (state)
        S_LOAD: begin
          if (in_valid) begin
            fill <= fill_new;
            if (last_sample) begin
              fill     <= '0;
              n        <= fill_new;
              sel_base <= '0;
              sel_k    <= fill_new;
              idx      <= '0;
              state    <= S_MED;
            end
          end
        end
        S_MED: begin
          if (pass_end) begin
            m   <= mid_val;
            idx <= '0;
            if (mad_factor == '0 || n < CW'(MIN_TRIM_COUNT)) begin
              res_med  <= mid_val;
              res_k    <= n;
              res_full <= 1'b1;
              state    <= S_EMIT;
            end else begin
              state <= S_DEV;
            end
          end
        end
        S_DEV: begin
          if (pass_end) begin
            idx   <= '0;
            state <= S_MAD;
          end
        end
        S_MAD: begin
          if (pass_end) begin
            mad   <= (mid_val < W'(MIN_MAD)) ? W'(MIN_MAD) : mid_val;
            state <= S_LIM;
          end
        end
        S_LIM: begin
          limit <= LW'(mad) * LW'(mad_factor);
          kept  <= '0;
          first <= '0;
          idx   <= '0;
          state <= S_CNT;
        end
        S_CNT: begin
          kept  <= kept_final;
          first <= first_final;
          if (pass_end) begin
            idx <= '0;
            if ({kept_final, 1'b0} >= {1'b0, n}) begin
              sel_base <= first_final;
              sel_k    <= kept_final;
              state    <= S_FIN;
            end else begin
              res_med  <= m;
              res_k    <= n;
              res_full <= 1'b1;
              state    <= S_EMIT;
            end
          end
        end
        S_FIN: begin
          if (pass_end) begin
            res_med  <= mid_val;
            res_k    <= sel_k;
            res_full <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            median_count     <= COUNT_W'(res_med);
            kept_count       <= KEPT_W'(res_k);
            used_full_window <= res_full;
            out_valid        <= 1'b1;
            state            <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

### src/mtm_sort_cell.sv
// ----------------------------------------------------------------------------
// mtm_sort_cell
// one cell of a sorted insertion chain: holds a value and a valid bit
// ----------------------------------------------------------------------------
module mtm_sort_cell import mtm_pkg::*; #(
  parameter int W = SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cell_op_t     op,
  input  logic [W-1:0] ins_data,
  input  logic [W-1:0] left_data,
  input  logic         left_valid,
  input  logic         left_gt,
  input  logic [W-1:0] right_data,
  input  logic         right_valid,
  output logic [W-1:0] data,
  output logic         valid,
  output logic         gt
);

  // empty cells count as larger than anything
  assign gt = !valid || (data > ins_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        CELL_INSERT: begin
          if (gt) valid <= left_gt ? left_valid : 1'b1;
        end
        CELL_SHIFT: valid <= right_valid;
        CELL_CLEAR: valid <= 1'b0;
        default:    valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      CELL_INSERT: begin
        if (gt) data <= left_gt ? left_data : ins_data;
      end
      CELL_SHIFT: data <= right_data;
      default:    data <= data;
    endcase
  end

endmodule

### src/mtm_sort_chain.sv
// ----------------------------------------------------------------------------
// mtm_sort_chain
// row of sort cells kept in ascending order, rotated toward the head to read
// ----------------------------------------------------------------------------
module mtm_sort_chain import mtm_pkg::*; #(
  parameter int N = MAX_SAMPLES_DEF,
  parameter int W = SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cell_op_t     op,
  input  logic [W-1:0] ins_data,
  output logic [W-1:0] head_data,
  output logic         head_valid
);

  logic [W-1:0] data_a  [N];
  logic         valid_a [N];
  logic         gt_a    [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] l_data, r_data;
    logic         l_valid, l_gt, r_valid;

    if (i == 0) begin : g_first
      assign l_data  = '0;
      assign l_valid = 1'b0;
      assign l_gt    = 1'b0;
    end else begin : g_mid
      assign l_data  = data_a[i-1];
      assign l_valid = valid_a[i-1];
      assign l_gt    = gt_a[i-1];
    end

    // rotation wraps the head back onto the tail
    assign r_data  = data_a[(i + 1) % N];
    assign r_valid = valid_a[(i + 1) % N];

    mtm_sort_cell #(.W(W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .ins_data   (ins_data),
      .left_data  (l_data),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .right_data (r_data),
      .right_valid(r_valid),
      .data       (data_a[i]),
      .valid      (valid_a[i]),
      .gt         (gt_a[i])
    );
  end

  assign head_data  = data_a[0];
  assign head_valid = valid_a[0];

endmodule

### src/mtm_checker.sv
// ----------------------------------------------------------------------------
// mtm_checker
// port-level checks on the trimmed median unit, bound to the top level
// ----------------------------------------------------------------------------
module mtm_checker import mtm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               last_sample,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] median_count,
  input logic [KEPT_W-1:0]  kept_count
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median_count))
    else $error("result beat changed while stalled");

  // closing beat stops the input while the window is worked on
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_sample |=> !in_ready)
    else $error("input taken during processing");

  // a result always covers at least one sample
  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kept_count != '0)
    else $error("empty result");

  // a new result appears only as loading resumes
  a_new_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result without return to loading");

endmodule

bind mad_trimmed_median_unit mtm_checker u_mtm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_sample (last_sample),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .median_count(median_count),
  .kept_count  (kept_count)
);

### verif/tb_mad_trimmed_median_unit.sv
// ----------------------------------------------------------------------------
// tb_mad_trimmed_median_unit
// drives windows of adc counts through the trimmed median unit, predicts the
// median, kept count and fallback flag per window, and compares each result
// beat against the oldest prediction; mad factor changes between phases
// ----------------------------------------------------------------------------
module tb_mad_trimmed_median_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mtm_pkg::*;

  localparam int WIN_MAX = MAX_SAMPLES_DEF;
  // worst latency after last beat, with margin
  localparam int DRAIN_CYCLES = 6 * WIN_MAX + 20;

  typedef struct packed {
    logic [COUNT_W-1:0] median;
    logic [KEPT_W-1:0]  kept;
    logic               full;
  } window_result_t;

  // scoreboard: holds window contents and the queue of predicted results
  class median_scoreboard;
    logic [COUNT_W-1:0]  window_q[$];
    logic [FACTOR_W-1:0] factor;
    window_result_t      pending_q[$];
    int                  errors;

    function new();
      factor = MAD_FACTOR_RESET;
      errors = 0;
    endfunction

    static function int mid_value(int a[$]);
      int n;
      n = a.size();
      if (n % 2) return a[n / 2];
      return (a[n / 2 - 1] + a[n / 2]) / 2;
    endfunction

    // note one accepted input beat; closes the window on last
    function void note_sample(logic [COUNT_W-1:0] cnt, logic last);
      int vals[$];
      int devs[$];
      int kept_vals[$];
      int n, m, mad, limit, dv;
      window_result_t r;
      if (window_q.size() < WIN_MAX) window_q.push_back(cnt);
      if (!last) return;
      foreach (window_q[i]) vals.push_back(int'(window_q[i]));
      window_q.delete();
      vals.sort();
      n = vals.size();
      m = mid_value(vals);
      r.median = m[COUNT_W-1:0];
      r.kept = n[KEPT_W-1:0];
      r.full = 1'b1;
      if (factor != 0 && n >= MIN_TRIM_COUNT) begin
        foreach (vals[i]) devs.push_back(vals[i] > m ? vals[i] - m : m - vals[i]);
        devs.sort();
        mad = mid_value(devs);
        if (mad < MIN_MAD) mad = MIN_MAD;
        limit = mad * int'(factor);
        foreach (vals[i]) begin
          dv = vals[i] > m ? vals[i] - m : m - vals[i];
          if (dv <= limit) kept_vals.push_back(vals[i]);
        end
        if (kept_vals.size() * 2 >= n) begin
          m = mid_value(kept_vals);
          r.median = m[COUNT_W-1:0];
          r.kept = KEPT_W'(kept_vals.size());
          r.full = 1'b0;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(window_result_t got);
      window_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat median=%0d kept=%0d full=%0b",
                 $time, got.median, got.kept, got.full);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.median !== want.median) begin
        $display("%0t: median_count expected %0d actual %0d", $time, want.median, got.median);
        errors++;
      end
      if (got.kept !== want.kept) begin
        $display("%0t: kept_count expected %0d actual %0d", $time, want.kept, got.kept);
        errors++;
      end
      if (got.full !== want.full) begin
        $display("%0t: used_full_window expected %0b actual %0b", $time, want.full, got.full);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [COUNT_W-1:0]  sample_count;
  logic                last_sample;
  logic                out_valid;
  logic                out_ready;
  logic [COUNT_W-1:0]  median_count;
  logic [KEPT_W-1:0]   kept_count;
  logic                used_full_window;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [FACTOR_W-1:0] cfg_data;

  median_scoreboard sb;
  int send_idle_pct;   // chance per cycle that the sender holds off
  int recv_idle_pct;   // chance per cycle that the receiver stalls
  int beats_sent;

  mad_trimmed_median_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_count(sample_count), .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .median_count(median_count), .kept_count(kept_count),
    .used_full_window(used_full_window),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous fixed limit
  initial begin
    #40ms;
    $display("tb_mad_trimmed_median_unit: done, errors");
    $finish;
  end

  // receiver: random stalls, checks every accepted result beat
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{median_count, kept_count, used_full_window});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one input beat; idles first at random, holds valid until accepted
  task automatic send_sample(logic [COUNT_W-1:0] cnt, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_count <= cnt;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(cnt, last);
    beats_sent++;
  endtask

  // wait until every prediction has been matched, then let the unit settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_factor(logic [FACTOR_W-1:0] f);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= f;
    do @(posedge clk); while (!cfg_ready);
    sb.factor = f;
    cfg_valid <= 1'b0;
  endtask

  // window of n counts around a center with spread and a few outliers
  task automatic send_window(int n, int center, int spread, int outlier_pct);
    int v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < outlier_pct) v = $urandom_range(4095);
      else v = center + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_sample(v[COUNT_W-1:0], i == n - 1);
    end
  endtask

  task automatic send_random_window();
    int n, sel;
    sel = $urandom_range(99);
    if (sel < 5) n = WIN_MAX;
    else if (sel < 8) n = WIN_MAX + $urandom_range(1, 6);   // overflow, drops
    else if (sel < 20) n = $urandom_range(1, 3);
    else n = $urandom_range(4, 16);
    if ($urandom_range(9) == 0) send_window(n, $urandom_range(4095), 2048, 0);
    else send_window(n, $urandom_range(4095), $urandom_range(30), $urandom_range(40));
  endtask

  initial begin
    logic [FACTOR_W-1:0] factors[6];
    sb = new();
    factors = '{8'd3, 8'd0, 8'd1, 8'd255, 8'd2, 8'd3};
    rst = 1'b1;
    in_valid = 1'b0;
    sample_count = '0;
    last_sample = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    beats_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single count, extremes, even and odd windows, overflow
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd5, 1'b0);
    send_sample(12'd5, 1'b0);
    send_sample(12'd5, 1'b1);
    send_sample(12'd100, 1'b0);
    send_sample(12'd101, 1'b0);
    send_sample(12'd102, 1'b0);
    send_sample(12'd4000, 1'b1);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b1);
    send_window(WIN_MAX + 3, 2000, 10, 10);
    write_factor(8'd0);
    send_window(5, 1000, 3, 40);
    write_factor(8'd255);
    send_window(6, 1000, 3, 40);

    // random phases over the idling patterns and factor settings
    for (int ph = 0; ph < 6; ph++) begin
      write_factor(factors[ph]);
      if (ph < 2) begin
        send_idle_pct = 28; recv_idle_pct = 57;
      end else if (ph < 4) begin
        send_idle_pct = 57; recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int w = 0; w < 7; w++) begin
        send_random_window();
        // hold off until the unit has emptied
        if (w == 5) begin
          in_valid <= 1'b0;
          while (sb.pending_q.size() != 0) @(posedge clk);
        end
      end
    end
    while (beats_sent < 700) send_random_window();

    wait_drained();
    if (sb.errors == 0 && sb.window_q.size() == 0)
      $display("tb_mad_trimmed_median_unit: done, clean");
    else
      $display("tb_mad_trimmed_median_unit: done, errors");
    $finish;
  end
endmodule
